FILE: hw/rtl/clwf_pkg.sv
// Shared widths, codes and controller/datapath interface types for the cursor list.
package clwf_pkg;

	localparam int NodesDef   = 16;
	localparam int MaxResults = 16;

	localparam int OpW     = 2;
	localparam int ValW    = 8;
	localparam int StatusW = 2;
	localparam int SlotW   = 4;
	localparam int LinkW   = 5;

	localparam logic [LinkW-1:0] LinkNull = '1;

	localparam logic [OpW-1:0] OpFront = 2'd0;
	localparam logic [OpW-1:0] OpBack  = 2'd1;
	localparam logic [OpW-1:0] OpSort  = 2'd2;
	localparam logic [OpW-1:0] OpRead  = 2'd3;

	localparam logic [StatusW-1:0] StOk    = 2'd0;
	localparam logic [StatusW-1:0] StFull  = 2'd1;
	localparam logic [StatusW-1:0] StEmpty = 2'd2;

	typedef enum logic [2:0] {
		EmitIns,
		EmitFull,
		EmitDone,
		EmitEmpty,
		EmitRead
	} emit_kind_t;

	typedef enum logic [1:0] {
		RdFree,
		RdHead,
		RdLink
	} rd_sel_t;

	typedef struct packed {
		logic       load_in;
		logic       rd_en;
		rd_sel_t    rd_sel;
		logic       take;
		logic       set_head;
		logic       wr_tail;
		logic       x_head;
		logic       x_link;
		logic       cnt_clr;
		logic       cnt_one;
		logic       cnt_inc;
		logic       len_load;
		logic       pass_clr;
		logic       pass_inc;
		logic       px_load;
		logic       py_step;
		logic       wr_xv;
		logic       emit;
		emit_kind_t emit_kind;
		logic       emit_last;
	} cmd_t;

	typedef struct packed {
		logic free_ok;
		logic head_ok;
		logic link_node;
		logic cnt_go;
		logic step_go;
		logic rd_go;
		logic pass_done;
		logic out_free;
		logic op_front;
	} dpst_t;

endpackage

FILE: hw/rtl/clwf_ctrl.sv
// Sequencer for inserts, tail walk, bubble sort passes and read-out.
module clwf_ctrl import clwf_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic [OpW-1:0] op,
	input  dpst_t          st,
	output cmd_t           cmd
);

	typedef enum logic [11:0] {
		S_IDLE  = 12'b0000_0000_0001,
		S_ALLOC = 12'b0000_0000_0010,
		S_TAKE  = 12'b0000_0000_0100,
		S_WALK  = 12'b0000_0000_1000,
		S_SORT  = 12'b0000_0001_0000,
		S_LEN   = 12'b0000_0010_0000,
		S_PASS  = 12'b0000_0100_0000,
		S_PX    = 12'b0000_1000_0000,
		S_PY    = 12'b0001_0000_0000,
		S_PEND  = 12'b0010_0000_0000,
		S_READ  = 12'b0100_0000_0000,
		S_EMIT  = 12'b1000_0000_0000
	} state_t;

	state_t     state_q, state_d;
	emit_kind_t kind_q, kind_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		kind_d  = kind_q;
		cmd     = '0;
		cmd.rd_sel    = RdLink;
		cmd.emit_kind = kind_q;
		cmd.emit_last = 1'b1;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					case (op) inside
						OpFront, OpBack: state_d = S_ALLOC;
						OpSort:          state_d = S_SORT;
						default:         state_d = S_READ;
					endcase
				end
			end
			S_ALLOC: begin
				if (!st.free_ok) begin
					kind_d  = EmitFull;
					state_d = S_EMIT;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RdFree;
					state_d    = S_TAKE;
				end
			end
			S_TAKE: begin
				cmd.take = 1'b1;
				kind_d   = EmitIns;
				if (st.op_front || !st.head_ok) begin
					cmd.set_head = 1'b1;
					state_d      = S_EMIT;
				end else begin
					cmd.rd_en   = 1'b1;
					cmd.rd_sel  = RdHead;
					cmd.x_head  = 1'b1;
					cmd.cnt_clr = 1'b1;
					state_d     = S_WALK;
				end
			end
			S_WALK: begin
				if (st.cnt_go) begin
					cmd.rd_en   = 1'b1;
					cmd.x_link  = 1'b1;
					cmd.cnt_inc = 1'b1;
				end else begin
					cmd.wr_tail = 1'b1;
					state_d     = S_EMIT;
				end
			end
			S_SORT: begin
				if (!st.head_ok) begin
					kind_d  = EmitDone;
					state_d = S_EMIT;
				end else begin
					cmd.rd_en   = 1'b1;
					cmd.rd_sel  = RdHead;
					cmd.cnt_one = 1'b1;
					state_d     = S_LEN;
				end
			end
			S_LEN: begin
				if (st.cnt_go) begin
					cmd.rd_en   = 1'b1;
					cmd.cnt_inc = 1'b1;
				end else begin
					cmd.len_load = 1'b1;
					cmd.pass_clr = 1'b1;
					state_d      = S_PASS;
				end
			end
			S_PASS: begin
				if (st.pass_done) begin
					kind_d  = EmitDone;
					state_d = S_EMIT;
				end else begin
					cmd.rd_en   = 1'b1;
					cmd.rd_sel  = RdHead;
					cmd.x_head  = 1'b1;
					cmd.cnt_clr = 1'b1;
					state_d     = S_PX;
				end
			end
			S_PX: begin
				if (st.link_node) begin
					cmd.px_load = 1'b1;
					cmd.rd_en   = 1'b1;
					state_d     = S_PY;
				end else begin
					cmd.pass_inc = 1'b1;
					state_d      = S_PASS;
				end
			end
			S_PY: begin
				// settle the lower value behind, carry the larger one forward
				cmd.py_step = 1'b1;
				cmd.cnt_inc = 1'b1;
				if (st.step_go) begin
					cmd.rd_en = 1'b1;
				end else begin
					state_d = S_PEND;
				end
			end
			S_PEND: begin
				cmd.wr_xv    = 1'b1;
				cmd.pass_inc = 1'b1;
				state_d      = S_PASS;
			end
			S_READ: begin
				if (!st.head_ok) begin
					kind_d  = EmitEmpty;
					state_d = S_EMIT;
				end else begin
					cmd.rd_en   = 1'b1;
					cmd.rd_sel  = RdHead;
					cmd.x_head  = 1'b1;
					cmd.cnt_clr = 1'b1;
					kind_d      = EmitRead;
					state_d     = S_EMIT;
				end
			end
			S_EMIT: begin
				// read-out stays here, one transfer per node
				if (st.out_free) begin
					cmd.emit = 1'b1;
					if (kind_q == EmitRead && st.rd_go) begin
						cmd.emit_last = 1'b0;
						cmd.rd_en     = 1'b1;
						cmd.x_link    = 1'b1;
						cmd.cnt_inc   = 1'b1;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q  <= EmitDone;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
		end
	end

endmodule

FILE: hw/rtl/clwf_dp.sv
// Datapath: node memory, list and free heads, walk pointers, counters and output register.
module clwf_dp import clwf_pkg::*; #(
	parameter int NODES = NodesDef
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [OpW-1:0]            op,
	input  logic signed [ValW-1:0]    value,
	input  cmd_t                      cmd,
	output dpst_t                     st,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [StatusW-1:0]        status,
	output logic [SlotW-1:0]          slot,
	output logic signed [ValW-1:0]    element,
	output logic                      last
);

	localparam int IdxW = $clog2(NODES);
	localparam int CntW = $clog2((NODES > MaxResults ? NODES : MaxResults) + 1);
	localparam logic [LinkW-1:0] FreeInit = LinkW'(NODES - 1);

	function automatic logic is_node(input logic [LinkW-1:0] p);
		return int'(p) < NODES;
	endfunction

	logic signed [ValW-1:0] val_mem [NODES];
	logic [LinkW-1:0]       link_mem [NODES];
	logic [NODES-1:0]       vld_q;

	logic signed [ValW-1:0] rd_val_q;
	logic [LinkW-1:0]       rd_link_q;
	logic [IdxW-1:0]        rd_idx_q;
	logic                   rd_vld_q;

	logic [LinkW-1:0]       free_head_q, list_head_q;
	logic [LinkW-1:0]       x_q, y_q, n_q;
	logic signed [ValW-1:0] xv_q, value_q;
	logic [OpW-1:0]         op_q;
	logic [CntW-1:0]        cnt_q, len_q, pass_q;
	logic [CntW-1:0]        cnt1;

	logic                   out_valid_q, last_q;
	logic [StatusW-1:0]     status_q;
	logic [SlotW-1:0]       slot_q;
	logic signed [ValW-1:0] element_q;

	logic signed [ValW-1:0] rd_value;
	logic [LinkW-1:0]       rd_link;
	logic [IdxW-1:0]        prev_idx;
	logic [LinkW-1:0]       rd_ptr;
	logic [IdxW-1:0]        rd_addr, free_addr, x_addr;
	logic                   swap;
	logic signed [ValW-1:0] lo_val, hi_val;
	logic                   val_we, link_we;
	logic [IdxW-1:0]        val_wa, link_wa;
	logic signed [ValW-1:0] val_wd;
	logic [LinkW-1:0]       link_wd;
	logic                   out_free;
	logic [StatusW-1:0]     em_status;
	logic [SlotW-1:0]       em_slot;
	logic signed [ValW-1:0] em_element;

	// a node never written reads as its reset contents
	assign prev_idx = rd_idx_q - IdxW'(1);
	assign rd_value = rd_vld_q ? rd_val_q : '0;
	assign rd_link  = rd_vld_q ? rd_link_q :
		((rd_idx_q == '0) ? LinkNull : LinkW'(prev_idx));

	always_comb begin
		case (cmd.rd_sel)
			RdFree:  rd_ptr = free_head_q;
			RdHead:  rd_ptr = list_head_q;
			default: rd_ptr = rd_link;
		endcase
	end

	assign rd_addr   = IdxW'(rd_ptr);
	assign free_addr = IdxW'(free_head_q);
	assign x_addr    = IdxW'(x_q);

	assign swap   = xv_q > rd_value;
	assign lo_val = swap ? rd_value : xv_q;
	assign hi_val = swap ? xv_q : rd_value;

	assign val_we  = cmd.take | cmd.py_step | cmd.wr_xv;
	assign val_wa  = cmd.take ? free_addr : x_addr;
	assign val_wd  = cmd.take ? value_q : (cmd.py_step ? lo_val : xv_q);
	assign link_we = cmd.take | cmd.wr_tail;
	assign link_wa = cmd.take ? free_addr : x_addr;
	assign link_wd = cmd.take ? ((op_q == OpFront) ? list_head_q : LinkNull) : n_q;

	always_ff @(posedge clk) begin
		if (val_we) begin
			val_mem[val_wa] <= val_wd;
		end
		if (link_we) begin
			link_mem[link_wa] <= link_wd;
		end
		if (cmd.rd_en) begin
			rd_val_q  <= val_mem[rd_addr];
			rd_link_q <= link_mem[rd_addr];
			rd_idx_q  <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (cmd.take) begin
				vld_q[free_addr] <= 1'b1;
			end
			if (cmd.rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign cnt1 = cnt_q + CntW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q <= FreeInit;
			list_head_q <= LinkNull;
			cnt_q       <= '0;
			len_q       <= '0;
			pass_q      <= '0;
		end else begin
			if (cmd.take) begin
				free_head_q <= rd_link;
			end
			if (cmd.set_head) begin
				list_head_q <= free_head_q;
			end
			if (cmd.cnt_clr) begin
				cnt_q <= '0;
			end else if (cmd.cnt_one) begin
				cnt_q <= CntW'(1);
			end else if (cmd.cnt_inc) begin
				cnt_q <= cnt1;
			end
			if (cmd.len_load) begin
				len_q <= cnt_q;
			end
			if (cmd.pass_clr) begin
				pass_q <= '0;
			end else if (cmd.pass_inc) begin
				pass_q <= pass_q + CntW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q    <= op;
			value_q <= value;
		end
		if (cmd.take) begin
			n_q <= free_head_q;
		end
		if (cmd.x_head) begin
			x_q <= list_head_q;
		end else if (cmd.x_link) begin
			x_q <= rd_link;
		end else if (cmd.py_step) begin
			x_q <= y_q;
		end
		if (cmd.px_load) begin
			xv_q <= rd_value;
			y_q  <= rd_link;
		end else if (cmd.py_step) begin
			xv_q <= hi_val;
			y_q  <= rd_link;
		end
	end

	always_comb begin
		em_status  = StOk;
		em_slot    = '0;
		em_element = '0;
		case (cmd.emit_kind)
			EmitIns:   em_slot = SlotW'(n_q);
			EmitFull:  em_status = StFull;
			EmitDone:  em_status = StOk;
			EmitEmpty: em_status = StEmpty;
			EmitRead: begin
				em_slot    = SlotW'(x_q);
				em_element = rd_value;
			end
			default:   em_status = StOk;
		endcase
	end

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			status_q  <= em_status;
			slot_q    <= em_slot;
			element_q <= em_element;
			last_q    <= cmd.emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign slot      = slot_q;
	assign element   = element_q;
	assign last      = last_q;

	assign st.free_ok   = is_node(free_head_q);
	assign st.head_ok   = is_node(list_head_q);
	assign st.link_node = is_node(rd_link);
	assign st.cnt_go    = is_node(rd_link) && (int'(cnt_q) < NODES);
	assign st.step_go   = is_node(rd_link) && (int'(cnt1) < NODES);
	assign st.rd_go     = is_node(rd_link) && (int'(cnt1) < NODES)
		&& (int'(cnt1) < MaxResults);
	assign st.pass_done = (pass_q == len_q);
	assign st.out_free  = out_free;
	assign st.op_front  = (op_q == OpFront);

endmodule

FILE: hw/rtl/cursor_list_with_free_list.sv
// Top level of the cursor-based linked list with free list over a fixed node pool.
//
//  channel  direction  handshake             payload
//  in       sink       in_valid / in_stall   op, value
//  out      source     out_valid / out_stall status, slot, element, last
//
// One item at a time; in_stall is high from the accepting edge until the sequencer is idle.
// Insert-last walks the list from its head to find the tail; insert-first does not walk.
// Sort over L nodes makes L bubble passes, one compare-and-swap step per cycle
// on the single read port of the node memory.
// Reset is immediate: per-node valid flags make unwritten nodes read as their reset contents.
// out_stall holds the sequencer in its emitting state; a result waits in the output register.
module cursor_list_with_free_list import clwf_pkg::*; #(
	parameter int NODES = NodesDef
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [OpW-1:0]         op,
	input  logic signed [ValW-1:0] value,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [StatusW-1:0]     status,
	output logic [SlotW-1:0]       slot,
	output logic signed [ValW-1:0] element,
	output logic                   last
);

	cmd_t  cmd;
	dpst_t st;

	clwf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.op       (op),
		.st       (st),
		.cmd      (cmd)
	);

	clwf_dp #(
		.NODES (NODES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.value     (value),
		.cmd       (cmd),
		.st        (st),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.slot      (slot),
		.element   (element),
		.last      (last)
	);

endmodule

FILE: test/cursor_list_with_free_list_tb.sv
// Self-checking testbench for the cursor list with free list: directed table, then random traffic.
`timescale 1ns / 1ps

module cursor_list_with_free_list_tb;
	import clwf_pkg::*;

	localparam int NODES    = NodesDef;
	localparam int CycLimit = 2_000_000;
	localparam int RandLen  = 330;
	localparam int PlanLen  = 26;

	typedef struct packed {
		logic [StatusW-1:0] status;
		logic [SlotW-1:0]   slot;
		logic [ValW-1:0]    element;
		logic               last;
	} result_t;

	typedef struct packed {
		logic [OpW-1:0]  op;
		logic [ValW-1:0] value;
		logic            typed;
		result_t         want;
	} row_t;

	localparam result_t NoRes = '0;

	// From an empty list, read and sort, fill the pool, then overflow it, read and sort; slots count down from the top.
	localparam row_t Plan [PlanLen] = '{
		'{OpRead,  8'h00, 1'b1, '{StEmpty, 4'd0,  8'h00, 1'b1}},
		'{OpSort,  8'h5a, 1'b1, '{StOk,    4'd0,  8'h00, 1'b1}},
		'{OpBack,  8'h7f, 1'b1, '{StOk,    4'd15, 8'h00, 1'b1}},
		'{OpFront, 8'h80, 1'b1, '{StOk,    4'd14, 8'h00, 1'b1}},
		'{OpBack,  8'hff, 1'b1, '{StOk,    4'd13, 8'h00, 1'b1}},
		'{OpRead,  8'h00, 1'b0, NoRes},
		'{OpSort,  8'hff, 1'b1, '{StOk,    4'd0,  8'h00, 1'b1}},
		'{OpRead,  8'h33, 1'b0, NoRes},
		'{OpFront, 8'h00, 1'b1, '{StOk,    4'd12, 8'h00, 1'b1}},
		'{OpBack,  8'h01, 1'b1, '{StOk,    4'd11, 8'h00, 1'b1}},
		'{OpFront, 8'h40, 1'b1, '{StOk,    4'd10, 8'h00, 1'b1}},
		'{OpBack,  8'hc0, 1'b1, '{StOk,    4'd9,  8'h00, 1'b1}},
		'{OpFront, 8'h55, 1'b1, '{StOk,    4'd8,  8'h00, 1'b1}},
		'{OpBack,  8'haa, 1'b1, '{StOk,    4'd7,  8'h00, 1'b1}},
		'{OpFront, 8'h7e, 1'b1, '{StOk,    4'd6,  8'h00, 1'b1}},
		'{OpBack,  8'h81, 1'b1, '{StOk,    4'd5,  8'h00, 1'b1}},
		'{OpFront, 8'h02, 1'b1, '{StOk,    4'd4,  8'h00, 1'b1}},
		'{OpBack,  8'hfe, 1'b1, '{StOk,    4'd3,  8'h00, 1'b1}},
		'{OpFront, 8'h10, 1'b1, '{StOk,    4'd2,  8'h00, 1'b1}},
		'{OpBack,  8'hef, 1'b1, '{StOk,    4'd1,  8'h00, 1'b1}},
		'{OpBack,  8'h7f, 1'b1, '{StOk,    4'd0,  8'h00, 1'b1}},
		'{OpFront, 8'h11, 1'b1, '{StFull,  4'd0,  8'h00, 1'b1}},
		'{OpBack,  8'h80, 1'b1, '{StFull,  4'd0,  8'h00, 1'b1}},
		'{OpRead,  8'h00, 1'b0, NoRes},
		'{OpSort,  8'h00, 1'b1, '{StOk,    4'd0,  8'h00, 1'b1}},
		'{OpRead,  8'hc3, 1'b0, NoRes}
	};

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_stall;
	logic [OpW-1:0]         op;
	logic signed [ValW-1:0] value;
	logic                   out_valid;
	logic                   out_stall;
	logic [StatusW-1:0]     status;
	logic [SlotW-1:0]       slot;
	logic signed [ValW-1:0] element;
	logic                   last;

	cursor_list_with_free_list #(.NODES(NODES)) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.slot      (slot),
		.element   (element),
		.last      (last)
	);

	// Shadow copy of the node pool
	logic signed [ValW-1:0] pool_val [NODES];
	logic [LinkW-1:0]       pool_lnk [NODES];
	logic [LinkW-1:0]       free_hd;
	logic [LinkW-1:0]       list_hd;

	result_t step_res [MaxResults];
	int      step_n;
	result_t pending [$];

	int errors;
	int sent_n;
	int got_n;
	int cyc;
	int op_seen [4];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit is_node(logic [LinkW-1:0] p);
		return p < NODES;
	endfunction

	function automatic logic [LinkW-1:0] link_after(logic [LinkW-1:0] p);
		return is_node(p) ? pool_lnk[p] : LinkNull;
	endfunction

	function automatic void add_res(logic [StatusW-1:0] st, logic [LinkW-1:0] sl,
			logic [ValW-1:0] el, logic lst);
		step_res[step_n] = '{st, sl[SlotW-1:0], el, lst};
		step_n++;
	endfunction

	function automatic void pool_reset();
		for (int i = 0; i < NODES; i++) begin
			pool_val[i] = '0;
			pool_lnk[i] = (i == 0) ? LinkNull : LinkW'(i - 1);
		end
		free_hd = LinkW'(NODES - 1);
		list_hd = LinkNull;
	endfunction

	// Apply one operation to the shadow pool and collect the results it should produce.
	function automatic void list_apply(logic [OpW-1:0] o, logic signed [ValW-1:0] v);
		logic [LinkW-1:0]       n;
		logic [LinkW-1:0]       t;
		logic [LinkW-1:0]       y;
		logic signed [ValW-1:0] tmp;
		int                     steps;
		int                     len;
		step_n = 0;
		case (o)
			OpFront, OpBack: begin
				n = free_hd;
				if (!is_node(n)) begin
					add_res(StFull, '0, '0, 1'b1);
				end else begin
					free_hd = pool_lnk[n];
					pool_val[n] = v;
					if (o == OpFront) begin
						pool_lnk[n] = list_hd;
						list_hd = n;
					end else begin
						pool_lnk[n] = LinkNull;
						if (!is_node(list_hd)) begin
							list_hd = n;
						end else begin
							t = list_hd;
							steps = 0;
							while (is_node(link_after(t)) && steps < NODES) begin
								t = link_after(t);
								steps++;
							end
							pool_lnk[t] = n;
						end
					end
					add_res(StOk, n, '0, 1'b1);
				end
			end
			OpSort: begin
				len = 0;
				t = list_hd;
				while (is_node(t) && len < NODES) begin
					len++;
					t = link_after(t);
				end
				for (int pass = 0; pass < len; pass++) begin
					t = list_hd;
					steps = 0;
					while (is_node(t) && is_node(link_after(t)) && steps < NODES) begin
						y = link_after(t);
						if (pool_val[t] > pool_val[y]) begin
							tmp = pool_val[t];
							pool_val[t] = pool_val[y];
							pool_val[y] = tmp;
						end
						t = y;
						steps++;
					end
				end
				add_res(StOk, '0, '0, 1'b1);
			end
			default: begin
				if (!is_node(list_hd)) begin
					add_res(StEmpty, '0, '0, 1'b1);
				end else begin
					t = list_hd;
					while (is_node(t) && step_n < MaxResults && step_n < NODES) begin
						add_res(StOk, t, pool_val[t], 1'b0);
						t = link_after(t);
					end
					step_res[step_n-1].last = 1'b1;
				end
			end
		endcase
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic log_fail(input string msg);
		errors++;
		if (errors <= 10)
			$display("%s", msg);
	endtask

	// Present one transfer, hold it until taken, then queue what it should produce.
	task automatic send_item(input logic [OpW-1:0] o, input logic [ValW-1:0] v,
			input logic typed, input result_t want);
		@(negedge clk);
		in_valid = 1'b1;
		op = o;
		value = v;
		do @(posedge clk); while (in_stall);
		list_apply(o, v);
		if (typed)
			pending.push_back(want);
		else
			for (int k = 0; k < step_n; k++)
				pending.push_back(step_res[k]);
		sent_n++;
		op_seen[o]++;
	endtask

	initial begin
		int gap;
		errors = 0;
		sent_n = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = OpFront;
		value = '0;
		op_seen = '{0, 0, 0, 0};
		pool_reset();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < PlanLen; i++) begin
			gap = pick_gap();
			if (gap > 0) begin
				@(negedge clk);
				in_valid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			send_item(Plan[i].op, Plan[i].value, Plan[i].typed, Plan[i].want);
		end

		for (int i = 0; i < RandLen; i++) begin
			if (i == RandLen / 2) begin
				// drain completely before carrying on
				@(negedge clk);
				in_valid = 1'b0;
				while (pending.size() != 0) @(posedge clk);
			end
			gap = ((i / 40) % 3 == 2) ? 0 : pick_gap();
			if (gap > 0) begin
				@(negedge clk);
				in_valid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			send_item(OpW'($urandom_range(0, 3)), ValW'($urandom), 1'b0, NoRes);
		end
		@(negedge clk);
		in_valid = 1'b0;

		while (pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (pending.size() != 0) begin
			errors += pending.size();
			$display("%0d expected results never arrived", pending.size());
		end
		$display("Ran %0d operations (%0d front, %0d back, %0d sort, %0d read-out)",
			sent_n, op_seen[OpFront], op_seen[OpBack], op_seen[OpSort], op_seen[OpRead]);
		$display("Checked %0d result transfers, %0d failures", got_n, errors);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Receiver side: random stalls, calm stretches, and one long hold-off.
	initial begin
		int  stall_left;
		bit  held_long;
		out_stall = 1'b0;
		stall_left = 0;
		held_long = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (!held_long && got_n >= 150) begin
				held_long = 1'b1;
				out_stall = 1'b1;
				repeat (300) @(negedge clk);
				out_stall = 1'b0;
			end else if (stall_left > 0) begin
				out_stall = 1'b1;
				stall_left--;
			end else begin
				out_stall = 1'b0;
				if ((cyc / 64) % 4 != 3)
					stall_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			got_n <= got_n + 1;
			if (pending.size() == 0) begin
				log_fail($sformatf("unexpected result: status %0d slot %0d element %0d last %0b",
					status, slot, element, last));
			end else begin
				want = pending.pop_front();
				if (status !== want.status)
					log_fail($sformatf("result %0d status: expected %0d, got %0d",
						got_n, want.status, status));
				if (slot !== want.slot)
					log_fail($sformatf("result %0d slot: expected %0d, got %0d",
						got_n, want.slot, slot));
				if (element !== want.element)
					log_fail($sformatf("result %0d element: expected %0d, got %0d",
						got_n, $signed(want.element), element));
				if (last !== want.last)
					log_fail($sformatf("result %0d last: expected %0b, got %0b",
						got_n, want.last, last));
			end
		end
	end

	initial got_n = 0;
	initial cyc = 0;

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc >= CycLimit) begin
			$display("Timeout after %0d cycles", cyc);
			$display("CHECKS FAILED");
			$finish;
		end
	end

endmodule

FILE: sim.f
hw/rtl/clwf_pkg.sv
hw/rtl/clwf_ctrl.sv
hw/rtl/clwf_dp.sv
hw/rtl/cursor_list_with_free_list.sv
test/cursor_list_with_free_list_tb.sv
